@@ hw/rtl/fqs_pkg.sv @@
`timescale 1ns / 1ps

package fqs_pkg;

   // operand split
   localparam int FRAC_W  = 32;
   localparam int VALUE_W = 64;
   localparam int ROOT_W  = 48;

   // first row: one quotient bit and one root bit per cell
   localparam int ROW_A_CELLS = 32;
   localparam int ROW_A_RAD_W = 64;

   // second row: root of 2^32 + quotient, 34-bit radicand, 17 root bits
   localparam int ROW_B_CELLS = 17;
   localparam int ROW_B_RAD_W = 34;

   localparam int PROD_W = FRAC_W + ROW_B_CELLS;

   // how the result of an item is formed
   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_NAN,
      KIND_SMALL,
      KIND_FULL
   } fqs_kind_type;

endpackage

@@ hw/rtl/fqs_div_cell.sv @@
`timescale 1ns / 1ps

// one restoring division step: one quotient bit per cell
module fqs_div_cell (
   input  logic                      clock,
   input  logic                      en,
   input  logic [fqs_pkg::FRAC_W-1:0] rem_i,
   input  logic [fqs_pkg::FRAC_W-1:0] dq_i,
   input  logic [fqs_pkg::FRAC_W-1:0] dvs_i,
   output logic [fqs_pkg::FRAC_W-1:0] rem_o,
   output logic [fqs_pkg::FRAC_W-1:0] dq_o,
   output logic [fqs_pkg::FRAC_W-1:0] dvs_o
);
   import fqs_pkg::*;

   logic [FRAC_W:0]   rem_sh;
   logic [FRAC_W:0]   diff;
   logic              ge;
   logic [FRAC_W-1:0] rem_ff, rem_in;
   logic [FRAC_W-1:0] dq_ff, dq_in;
   logic [FRAC_W-1:0] dvs_ff;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      rem_sh = {rem_i, dq_i[FRAC_W-1]};
      diff   = rem_sh - {1'b0, dvs_i};
      ge     = (rem_sh >= {1'b0, dvs_i});
      rem_in = ge ? diff[FRAC_W-1:0] : rem_sh[FRAC_W-1:0];
      dq_in  = {dq_i[FRAC_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
         dvs_ff <= dvs_i;
      end
   end

   assign rem_o = rem_ff;
   assign dq_o  = dq_ff;
   assign dvs_o = dvs_ff;

endmodule

@@ hw/rtl/fqs_root_cell.sv @@
`timescale 1ns / 1ps

// one digit-by-digit square root step: one root bit per cell
module fqs_root_cell #(
   parameter int RAD_W = fqs_pkg::ROW_A_RAD_W,
   parameter int RES_W = fqs_pkg::ROW_A_CELLS
) (
   input  logic             clock,
   input  logic             en,
   input  logic [RAD_W-1:0] rad_i,
   input  logic [RES_W+1:0] rem_i,
   input  logic [RES_W-1:0] res_i,
   output logic [RAD_W-1:0] rad_o,
   output logic [RES_W+1:0] rem_o,
   output logic [RES_W-1:0] res_o
);
   logic [RES_W+1:0] rem_sh;
   logic [RES_W+1:0] trial;
   logic             ge;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RES_W+1:0] rem_ff, rem_in;
   logic [RES_W-1:0] res_ff, res_in;

   // bring down two radicand bits, compare against 4*root+1
   always_comb begin
      rem_sh = {rem_i[RES_W-1:0], rad_i[RAD_W-1:RAD_W-2]};
      trial  = {res_i, 2'b01};
      ge     = (rem_sh >= trial);
      rem_in = ge ? (rem_sh - trial) : rem_sh;
      res_in = {res_i[RES_W-2:0], ge};
      rad_in = {rad_i[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= rad_in;
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign rad_o = rad_ff;
   assign rem_o = rem_ff;
   assign res_o = res_ff;

endmodule

@@ hw/rtl/fixed_point_q32_32_sqrt.sv @@
`timescale 1ns / 1ps

// Square root of a signed 32.32 value, returned as an unsigned 16.32 value in
// 48 bits with a not-a-number flag for negative operands. The block takes one
// item per cycle while the output is not stalled; each item passes through
// 32 cells that each produce one quotient bit of fraction/integer and one bit
// of the 32-bit root, 17 cells that produce the correction root one bit each,
// and one multiply stage into the output register. A stall on the result side
// holds the whole row of cells.
module fixed_point_q32_32_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fqs_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fqs_pkg::ROOT_W-1:0]  rsp_root,
   output logic                        rsp_nan_flag
);
   import fqs_pkg::*;

   localparam int NA    = ROW_A_CELLS;
   localparam int NB    = ROW_B_CELLS;
   localparam int DEPTH = NA + NB;

   logic advance;

   // first row links
   logic [FRAC_W-1:0]      a_rem [NA+1];
   logic [FRAC_W-1:0]      a_dq  [NA+1];
   logic [FRAC_W-1:0]      a_dvs [NA+1];
   logic [ROW_A_RAD_W-1:0] a_rad [NA+1];
   logic [NA+1:0]          a_srm [NA+1];
   logic [NA-1:0]          a_res [NA+1];

   // second row links
   logic [ROW_B_RAD_W-1:0] b_rad [NB+1];
   logic [NB+1:0]          b_srm [NB+1];
   logic [NB-1:0]          b_res [NB+1];

   // side chains
   logic                   vld_ff  [DEPTH];
   fqs_kind_type           kind_ff [DEPTH];
   logic [NA-1:0]          c_ff    [NB];

   logic [FRAC_W-1:0]      ipart, fpart;
   fqs_kind_type           kind_in;

   logic [PROD_W-1:0]      prod;
   logic                   rsp_valid_ff;
   logic [ROOT_W-1:0]      rsp_root_ff, rsp_root_in;
   logic                   rsp_nan_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // classify the operand
   always_comb begin
      ipart = req_value[VALUE_W-1:FRAC_W];
      fpart = req_value[FRAC_W-1:0];
      priority if (req_value == '0)    kind_in = KIND_ZERO;
      else if (req_value[VALUE_W-1])   kind_in = KIND_NAN;
      else if (ipart == '0)            kind_in = KIND_SMALL;
      else                             kind_in = KIND_FULL;
   end

   // row inputs
   assign a_rem[0] = '0;
   assign a_dq[0]  = fpart;
   assign a_dvs[0] = ipart;
   assign a_rad[0] = (ipart == '0) ? {fpart, {FRAC_W{1'b0}}} : {ipart, {FRAC_W{1'b0}}};
   assign a_srm[0] = '0;
   assign a_res[0] = '0;

   assign b_rad[0] = {2'b01, a_dq[NA]};
   assign b_srm[0] = '0;
   assign b_res[0] = '0;

   // first row: division and integer root side by side
   for (genvar k = 0; k < NA; k++) begin : g_row_a
      fqs_div_cell u_div (
         .clock (clock),
         .en    (advance),
         .rem_i (a_rem[k]),
         .dq_i  (a_dq[k]),
         .dvs_i (a_dvs[k]),
         .rem_o (a_rem[k+1]),
         .dq_o  (a_dq[k+1]),
         .dvs_o (a_dvs[k+1])
      );
      fqs_root_cell #(
         .RAD_W (ROW_A_RAD_W),
         .RES_W (NA)
      ) u_root (
         .clock (clock),
         .en    (advance),
         .rad_i (a_rad[k]),
         .rem_i (a_srm[k]),
         .res_i (a_res[k]),
         .rad_o (a_rad[k+1]),
         .rem_o (a_srm[k+1]),
         .res_o (a_res[k+1])
      );
   end

   // second row: root of one plus fraction over integer
   for (genvar j = 0; j < NB; j++) begin : g_row_b
      fqs_root_cell #(
         .RAD_W (ROW_B_RAD_W),
         .RES_W (NB)
      ) u_root (
         .clock (clock),
         .en    (advance),
         .rad_i (b_rad[j]),
         .rem_i (b_srm[j]),
         .res_i (b_res[j]),
         .rad_o (b_rad[j+1]),
         .rem_o (b_srm[j+1]),
         .res_o (b_res[j+1])
      );
   end

   // valid and kind travel with the cells
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff[0] <= kind_in;
         for (int i = 1; i < DEPTH; i++) kind_ff[i] <= kind_ff[i-1];
         c_ff[0] <= a_res[NA];
         for (int i = 1; i < NB; i++) c_ff[i] <= c_ff[i-1];
      end
   end

   // final product and result select
   always_comb begin
      prod = {{NB{1'b0}}, c_ff[NB-1]} * {{NA{1'b0}}, b_res[NB]};
      unique case (kind_ff[DEPTH-1])
         KIND_ZERO:  rsp_root_in = '0;
         KIND_NAN:   rsp_root_in = '0;
         KIND_SMALL: rsp_root_in = {{(ROOT_W-NA){1'b0}}, c_ff[NB-1]};
         KIND_FULL:  rsp_root_in = prod[ROOT_W-1:0];
         default:    rsp_root_in = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_root_ff <= rsp_root_in;
         rsp_nan_ff  <= (kind_ff[DEPTH-1] == KIND_NAN);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_root     = rsp_root_ff;
   assign rsp_nan_flag = rsp_nan_ff;

   // a negative operand never yields a nonzero root
   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nan_ff |-> rsp_root_ff == '0)
      else $error("nan item with nonzero root");

   // a stall freezes the cell row
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[DEPTH-1]) && $stable(vld_ff[0]))
      else $error("cell row moved during stall");

   // the last cell hands its item to the output register
   a_last_out: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[DEPTH-1] |=> rsp_valid_ff)
      else $error("item lost between last cell and output");

   // a taken item enters the first cell
   a_first_in: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted item not in first cell");

endmodule
